>>> hdl/xdr_pkg.sv
package xdr_pkg;

  localparam int unsigned PosW = 6;

  typedef logic [PosW-1:0] pos_t;

  // recogniser positions
  localparam pos_t POS_BEGIN    = 6'd0;
  localparam pos_t POS_PFX_LAST = 6'd4;
  localparam pos_t POS_PFX_WS   = 6'd5;
  localparam pos_t POS_DECL     = 6'd6;
  localparam pos_t POS_KW0      = 6'd7;
  localparam pos_t POS_KW1      = 6'd17;
  localparam pos_t POS_KW2      = 6'd28;
  localparam pos_t POS_CLOSE    = 6'd41;
  localparam pos_t POS_CLOSEQ   = 6'd42;
  localparam pos_t POS_END      = 6'd63;

  typedef logic [1:0] kw_t;
  localparam kw_t KW_VERSION    = 2'd0;
  localparam kw_t KW_ENCODING   = 2'd1;
  localparam kw_t KW_STANDALONE = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DOC      = 2'd0;
  localparam kind_t KIND_VERSION  = 2'd1;
  localparam kind_t KIND_ENCODING = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_SCAN   = 2'd0;
  localparam status_t ST_NODECL = 2'd1;
  localparam status_t ST_CLOSED = 2'd2;
  localparam status_t ST_BROKEN = 2'd3;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_Y      = 8'h79;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_S  = 8'h73;

  // one accepted byte's results: put-back prefix bytes then the data byte
  typedef struct packed {
    logic       emit;
    logic [2:0] npb;
    logic [7:0] data;
    kind_t      kind;
    logic       sa;
    status_t    status;
  } burst_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = CH_LT;
      3'd1:    r = CH_QMARK;
      3'd2:    r = "x";
      3'd3:    r = "m";
      3'd4:    r = "l";
      default: r = CH_LT;
    endcase
    return r;
  endfunction

  function automatic pos_t kw_base(input kw_t kw);
    pos_t r;
    unique case (kw)
      KW_VERSION:  r = POS_KW0;
      KW_ENCODING: r = POS_KW1;
      default:     r = POS_KW2;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_len(input kw_t kw);
    logic [3:0] r;
    unique case (kw)
      KW_VERSION:  r = 4'd7;
      KW_ENCODING: r = 4'd8;
      default:     r = 4'd10;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input kw_t kw, input logic [3:0] m);
    logic [7:0] r;
    r = 8'h00;
    unique case (kw)
      KW_VERSION: begin
        unique case (m)
          4'd0:    r = "v";
          4'd1:    r = "e";
          4'd2:    r = "r";
          4'd3:    r = "s";
          4'd4:    r = "i";
          4'd5:    r = "o";
          4'd6:    r = "n";
          default: r = 8'h00;
        endcase
      end
      KW_ENCODING: begin
        unique case (m)
          4'd0:    r = "e";
          4'd1:    r = "n";
          4'd2:    r = "c";
          4'd3:    r = "o";
          4'd4:    r = "d";
          4'd5:    r = "i";
          4'd6:    r = "n";
          4'd7:    r = "g";
          default: r = 8'h00;
        endcase
      end
      default: begin
        unique case (m)
          4'd0:    r = "s";
          4'd1:    r = "t";
          4'd2:    r = "a";
          4'd3:    r = "n";
          4'd4:    r = "d";
          4'd5:    r = "a";
          4'd6:    r = "l";
          4'd7:    r = "o";
          4'd8:    r = "n";
          4'd9:    r = "e";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> hdl/xdr_parser.sv
module xdr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data,
  output xdr_pkg::burst_t burst
);

  xdr_pkg::pos_t    pos_r, pos_nxt;
  logic             flag_r, flag_nxt;
  xdr_pkg::status_t outc_r, outc_nxt;

  logic             emit;
  logic [2:0]       npb;
  xdr_pkg::kind_t   kind;

  xdr_pkg::kw_t     kw;
  xdr_pkg::pos_t    base;
  xdr_pkg::pos_t    off_w;
  logic [3:0]       len;
  logic [3:0]       off;
  logic [3:0]       m;
  logic [7:0]       quote_c;

  assign kw      = (pos_r < xdr_pkg::POS_KW1) ? xdr_pkg::KW_VERSION :
                   (pos_r < xdr_pkg::POS_KW2) ? xdr_pkg::KW_ENCODING :
                                                xdr_pkg::KW_STANDALONE;
  assign base    = xdr_pkg::kw_base(kw);
  assign len     = xdr_pkg::kw_len(kw);
  assign off_w   = pos_r - base;
  assign off     = off_w[3:0];
  assign m       = off + 4'd1;
  assign quote_c = (off == len + 4'd1) ? xdr_pkg::CH_DQUOTE : xdr_pkg::CH_SQUOTE;

  always_comb begin
    pos_nxt  = pos_r;
    flag_nxt = flag_r;
    outc_nxt = outc_r;
    emit     = 1'b0;
    npb      = 3'd0;
    kind     = xdr_pkg::KIND_DOC;
    priority if (pos_r == xdr_pkg::POS_BEGIN) begin
      if (data == xdr_pkg::CH_LT) begin
        pos_nxt = 6'd1;
      end else begin
        pos_nxt  = xdr_pkg::POS_END;
        outc_nxt = xdr_pkg::ST_NODECL;
        emit     = 1'b1;
      end
    end else if (pos_r <= xdr_pkg::POS_PFX_LAST) begin
      if (data == xdr_pkg::prefix_char(pos_r[2:0])) begin
        pos_nxt = pos_r + 6'd1;
      end else begin
        pos_nxt  = xdr_pkg::POS_END;
        outc_nxt = xdr_pkg::ST_NODECL;
        emit     = 1'b1;
        npb      = pos_r[2:0];
      end
    end else if (pos_r == xdr_pkg::POS_PFX_WS) begin
      if (xdr_pkg::is_ws(data)) begin
        pos_nxt = xdr_pkg::POS_DECL;
      end else begin
        pos_nxt  = xdr_pkg::POS_END;
        outc_nxt = xdr_pkg::ST_NODECL;
        emit     = 1'b1;
        npb      = 3'd5;
      end
    end else if (pos_r == xdr_pkg::POS_DECL) begin
      priority if (data == xdr_pkg::CH_QMARK) begin
        pos_nxt = xdr_pkg::POS_CLOSEQ;
      end else if (data == xdr_pkg::CH_LOW_V) begin
        pos_nxt = xdr_pkg::POS_KW0;
      end else if (data == xdr_pkg::CH_LOW_E) begin
        pos_nxt = xdr_pkg::POS_KW1;
      end else if (data == xdr_pkg::CH_LOW_S) begin
        pos_nxt = xdr_pkg::POS_KW2;
      end else if (!xdr_pkg::is_ws(data)) begin
        pos_nxt  = xdr_pkg::POS_END;
        outc_nxt = xdr_pkg::ST_BROKEN;
        emit     = 1'b1;
      end else begin
        pos_nxt = pos_r;
      end
    end else if (pos_r >= xdr_pkg::POS_KW0 && pos_r < xdr_pkg::POS_CLOSE) begin
      priority if (off < len) begin
        if (m < len) begin
          if (data == xdr_pkg::kw_char(kw, m)) begin
            pos_nxt = base + {2'b00, m};
          end else begin
            pos_nxt  = xdr_pkg::POS_END;
            outc_nxt = xdr_pkg::ST_BROKEN;
            emit     = 1'b1;
          end
        end else if (data == xdr_pkg::CH_EQ) begin
          pos_nxt = base + {2'b00, len};
        end else if (!xdr_pkg::is_ws(data)) begin
          pos_nxt  = xdr_pkg::POS_END;
          outc_nxt = xdr_pkg::ST_BROKEN;
          emit     = 1'b1;
        end
      end else if (off == len) begin
        priority if (data == xdr_pkg::CH_DQUOTE) begin
          pos_nxt = base + {2'b00, len} + 6'd1;
        end else if (data == xdr_pkg::CH_SQUOTE) begin
          pos_nxt = base + {2'b00, len} + 6'd2;
        end else if (!xdr_pkg::is_ws(data)) begin
          pos_nxt  = xdr_pkg::POS_END;
          outc_nxt = xdr_pkg::ST_BROKEN;
          emit     = 1'b1;
        end else begin
          pos_nxt = pos_r;
        end
      end else begin
        priority if (data == quote_c) begin
          pos_nxt = xdr_pkg::POS_DECL;
        end else if (kw == xdr_pkg::KW_STANDALONE) begin
          if (data == xdr_pkg::CH_Y) begin
            flag_nxt = 1'b1;
          end else if (data == xdr_pkg::CH_N) begin
            flag_nxt = 1'b0;
          end
        end else begin
          emit = 1'b1;
          kind = (kw == xdr_pkg::KW_VERSION) ? xdr_pkg::KIND_VERSION
                                             : xdr_pkg::KIND_ENCODING;
        end
      end
    end else if (pos_r == xdr_pkg::POS_CLOSE) begin
      pos_nxt  = xdr_pkg::POS_END;
      outc_nxt = xdr_pkg::ST_CLOSED;
      emit     = 1'b1;
    end else if (pos_r == xdr_pkg::POS_CLOSEQ) begin
      if (data == xdr_pkg::CH_GT) begin
        pos_nxt = xdr_pkg::POS_CLOSE;
      end else begin
        pos_nxt  = xdr_pkg::POS_END;
        outc_nxt = xdr_pkg::ST_BROKEN;
        emit     = 1'b1;
      end
    end else begin
      emit = 1'b1;
    end
  end

  assign burst.emit   = emit;
  assign burst.npb    = npb;
  assign burst.data   = data;
  assign burst.kind   = kind;
  assign burst.sa     = flag_r;
  assign burst.status = outc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= xdr_pkg::POS_BEGIN;
      flag_r <= 1'b0;
      outc_r <= xdr_pkg::ST_SCAN;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      flag_r <= flag_nxt;
      outc_r <= outc_nxt;
    end
  end

endmodule

>>> hdl/xdr_sequencer.sv
module xdr_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  xdr_pkg::burst_t  burst,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output xdr_pkg::kind_t   out_kind,
  output logic             out_standalone,
  output xdr_pkg::status_t out_decl_status,
  output logic             out_last
);

  logic            valid_r;
  logic [2:0]      idx_r;
  xdr_pkg::burst_t desc_r;
  logic            cur_last;

  assign cur_last = (idx_r == desc_r.npb);
  assign load_ok  = !valid_r || (cur_last && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else if (accept) begin
      valid_r <= burst.emit;
      idx_r   <= 3'd0;
    end else if (valid_r && !out_stall) begin
      if (cur_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && burst.emit) begin
      desc_r <= burst;
    end
  end

  // put-back prefix bytes first, the accepted byte on the final transfer
  assign out_valid       = valid_r;
  assign out_byte        = cur_last ? desc_r.data : xdr_pkg::prefix_char(idx_r);
  assign out_kind        = cur_last ? desc_r.kind : xdr_pkg::KIND_DOC;
  assign out_standalone  = desc_r.sa;
  assign out_decl_status = desc_r.status;
  assign out_last        = cur_last;

endmodule

>>> hdl/xml_declaration_recognizer_unit.sv
// Recognises a leading "<?xml " declaration in a byte stream, tagging version and encoding
// value bytes and tracking the standalone flag; afterwards bytes pass straight through.
// One byte is taken per cycle while in_stall is low. Bytes absorbed by the declaration give
// no transfer; the byte that ends recognition after a partial prefix match gives one transfer
// per put-back prefix byte plus one, so in_stall is held while the result register drains
// that burst. The output stage lets the next byte in on the cycle the final transfer goes.
module xml_declaration_recognizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_standalone,
  output logic [1:0] out_decl_status,
  output logic       out_last
);

  xdr_pkg::burst_t burst;
  logic            load_ok;
  logic            accept;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  xdr_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .data  (in_data_byte),
    .burst (burst)
  );

  xdr_sequencer u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .burst          (burst),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_standalone (out_standalone),
    .out_decl_status(out_decl_status),
    .out_last       (out_last)
  );

endmodule

>>> hdl/xdr_checker.sv
module xdr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_standalone,
  input logic [1:0] out_decl_status,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_last) && $stable(out_decl_status))
    else $error("stalled result changed");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result stage");

  a_value_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != xdr_pkg::KIND_DOC |->
      out_last && out_decl_status == xdr_pkg::ST_SCAN && out_kind <= xdr_pkg::KIND_ENCODING)
    else $error("bad value byte transfer");

  a_putback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      out_kind == xdr_pkg::KIND_DOC && out_decl_status == xdr_pkg::ST_NODECL)
    else $error("put-back byte outside no-declaration burst");

endmodule

bind xml_declaration_recognizer_unit xdr_checker u_chk (.*);
